// ===== rtl/wbps_pkg.sv =====
// Package for the wildcard byte pattern scanner: shared types, register codes and widths.
// No dependencies; every other file of the block imports it.
package wbps_pkg;

    // Defaults for the top-level parameters.
    localparam int SIGNATURE_MAX_DEF = 32;
    localparam int OFFSET_BITS_DEF   = 32;

    // Signature positions that the registers can describe.
    localparam int SIG_REG_BYTES = 32;
    localparam int SIG_SEL_W     = 5;
    // Wide enough for any signature position up to the largest SIGNATURE_MAX.
    localparam int POS_W         = 7;

    localparam int CFG_LEN_W     = 6;
    localparam int WILD_W        = 32;
    localparam int OUT_OFFSET_W  = 32;

    localparam int APB_DATA_W    = 64;
    localparam int APB_ADDR_W    = 6;
    localparam int REG_SEL_LSB   = 3;
    localparam int REG_SEL_W     = 3;

    typedef enum logic [REG_SEL_W-1:0] {
        REG_SIG_A   = 3'd0,
        REG_SIG_B   = 3'd1,
        REG_SIG_C   = 3'd2,
        REG_SIG_D   = 3'd3,
        REG_WILD    = 3'd4,
        REG_SIG_LEN = 3'd5
    } reg_sel_t;

    typedef logic [SIG_REG_BYTES-1:0][7:0] sig_bytes_t;

    typedef struct packed {
        sig_bytes_t          sig;
        logic [WILD_W-1:0]   wild;
        logic [CFG_LEN_W-1:0] len;
    } cfg_t;

endpackage

// ===== rtl/wbps_regs.sv =====
// APB register file of the scanner: signature bytes, wildcard mask and signature length.
// Depends on wbps_pkg.
module wbps_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wbps_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [wbps_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [wbps_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic                              wr_strobe,
    output wbps_pkg::cfg_t                    cfg
);
    import wbps_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_sel_t sel;

    assign sel       = reg_sel_t'(paddr[REG_SEL_LSB +: REG_SEL_W]);
    assign pready    = 1'b1;
    assign wr_strobe = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_strobe)
        begin
            case (sel)
                REG_SIG_A:   cfg_next.sig[7:0]   = pwdata;
                REG_SIG_B:   cfg_next.sig[15:8]  = pwdata;
                REG_SIG_C:   cfg_next.sig[23:16] = pwdata;
                REG_SIG_D:   cfg_next.sig[31:24] = pwdata;
                REG_WILD:    cfg_next.wild       = pwdata[WILD_W-1:0];
                REG_SIG_LEN: cfg_next.len        = pwdata[CFG_LEN_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sig  <= '0;
            cfg_reg.wild <= '0;
            cfg_reg.len  <= CFG_LEN_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (sel)
            REG_SIG_A:   prdata = cfg_reg.sig[7:0];
            REG_SIG_B:   prdata = cfg_reg.sig[15:8];
            REG_SIG_C:   prdata = cfg_reg.sig[23:16];
            REG_SIG_D:   prdata = cfg_reg.sig[31:24];
            REG_WILD:    prdata = APB_DATA_W'(cfg_reg.wild);
            REG_SIG_LEN: prdata = APB_DATA_W'(cfg_reg.len);
            default:     prdata = '0;
        endcase
    end

endmodule

// ===== rtl/wbps_cell.sv =====
// One window cell of the scanner: holds one window byte and the signature byte aligned to it.
// Depends on wbps_pkg.
module wbps_cell #(
    parameter int SIGNATURE_MAX = wbps_pkg::SIGNATURE_MAX_DEF,
    parameter int CELL_IDX      = 0,
    localparam int IDX_W        = (SIGNATURE_MAX > 1) ? $clog2(SIGNATURE_MAX) : 1
) (
    input  logic              clk,
    input  logic              shift_en,
    input  logic [7:0]        d_in,
    output logic [7:0]        d_out,
    input  wbps_pkg::cfg_t    cfg,
    input  logic [IDX_W-1:0]  len_m1,
    output logic              eq
);
    import wbps_pkg::*;

    localparam logic [POS_W-1:0] CELL_POS = POS_W'(CELL_IDX);

    logic [7:0]           byte_reg;
    logic [7:0]           sig_reg;
    logic [7:0]           sig_next;
    logic                 care_reg;
    logic                 care_next;
    logic [POS_W-1:0]     k;
    logic [SIG_SEL_W-1:0] k_sel;
    logic                 active;

    // The cell at window place j meets signature position len_m1 - j.
    assign k      = POS_W'(len_m1) - CELL_POS;
    assign k_sel  = k[SIG_SEL_W-1:0];
    assign active = CELL_POS <= POS_W'(len_m1);

    always_comb
    begin
        care_next = 1'b0;
        sig_next  = '0;
        if (active)
        begin
            if (k < POS_W'(SIG_REG_BYTES))
            begin
                care_next = !cfg.wild[k_sel];
                sig_next  = cfg.sig[k_sel];
            end
            else
            begin
                care_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sig_reg  <= sig_next;
        care_reg <= care_next;
        if (shift_en)
        begin
            byte_reg <= d_in;
        end
    end

    assign d_out = byte_reg;
    // Compare against the byte that this cell takes on the current shift.
    assign eq    = !care_reg || (d_in == sig_reg);

endmodule

// ===== rtl/wildcard_byte_pattern_scan_top.sv =====
// Wildcard byte pattern scanner: one byte item per cycle unless stalled, and one registered result per region.
// Latency: the result of an item is shown in the cycle after the item is accepted.
// Throughput: one byte item per cycle while byte_ready is high, set by the single compare stage across the cell row.
// After reset and after a configuration write the byte channel pauses while the two settle flags are set.
// Reset (rst_n, asynchronous, active low) clears position, done flag and the result valid flag.
// Depends on wbps_pkg, wbps_regs and wbps_cell.
module wildcard_byte_pattern_scan_top #(
    parameter int SIGNATURE_MAX = wbps_pkg::SIGNATURE_MAX_DEF,
    parameter int OFFSET_BITS   = wbps_pkg::OFFSET_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Byte items of the scanned region.
    input  logic                                 byte_valid,
    output logic                                 byte_ready,
    input  logic [7:0]                           region_byte,
    input  logic                                 first_in_region,
    input  logic                                 last_in_region,
    // Result items, one per region.
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic                                 found,
    output logic [wbps_pkg::OUT_OFFSET_W-1:0]    match_offset,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [wbps_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [wbps_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [wbps_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import wbps_pkg::*;

    localparam int IDX_W = (SIGNATURE_MAX > 1) ? $clog2(SIGNATURE_MAX) : 1;
    localparam logic [POS_W-1:0] SMAX_POS = POS_W'(SIGNATURE_MAX);

    // Configuration registers and the write strobe.
    cfg_t cfg;
    logic wr_strobe;

    wbps_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .wr_strobe (wr_strobe),
        .cfg       (cfg)
    );

    // The signature length actually used, less one. A length of zero acts as one, and a
    // length beyond the window acts as the full window.
    logic [POS_W-1:0] len_ext;
    logic [IDX_W-1:0] used_m1;
    logic [IDX_W-1:0] len_m1_reg;

    assign len_ext = POS_W'(cfg.len);

    always_comb
    begin
        if (len_ext == '0)
        begin
            used_m1 = '0;
        end
        else if (len_ext > SMAX_POS)
        begin
            used_m1 = IDX_W'(SIGNATURE_MAX - 1);
        end
        else
        begin
            used_m1 = IDX_W'(len_ext - POS_W'(1));
        end
    end

    // The cells register their aligned signature bytes every cycle, from the length copy
    // registered here, so a fresh write passes the length copy and then the cell registers
    // before it reaches the cells. The two settle flags hold the byte channel off meanwhile.
    logic settle_reg;
    logic settle_late_reg;

    always_ff @(posedge clk)
    begin
        len_m1_reg <= used_m1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg      <= 1'b1;
            settle_late_reg <= 1'b1;
        end
        else
        begin
            settle_reg      <= wr_strobe;
            settle_late_reg <= settle_reg;
        end
    end

    // Handshake. The result register frees itself in the same cycle that it is taken,
    // so bytes keep flowing one per cycle while results are drained.
    logic result_valid_reg;
    logic accept;

    assign byte_ready = (!result_valid_reg || result_ready) && !settle_reg && !settle_late_reg
                        && !wr_strobe;
    assign accept     = byte_valid && byte_ready;

    // The row of cells forms the shift window, newest byte in cell 0. Each cell compares
    // the byte it is about to take with its aligned signature byte.
    logic [7:0]               chain [SIGNATURE_MAX+1];
    logic [SIGNATURE_MAX-1:0] eq_vec;

    assign chain[0] = region_byte;

    for (genvar j = 0; j < SIGNATURE_MAX; j++)
    begin : g_cell
        wbps_cell #(
            .SIGNATURE_MAX (SIGNATURE_MAX),
            .CELL_IDX      (j)
        ) u_cell (
            .clk      (clk),
            .shift_en (accept),
            .d_in     (chain[j]),
            .d_out    (chain[j+1]),
            .cfg      (cfg),
            .len_m1   (len_m1_reg),
            .eq       (eq_vec[j])
        );
    end

    // Region tracking. A first mark restarts the position and clears the done flag before
    // the byte is counted. The position saturates at all ones.
    logic [OFFSET_BITS-1:0] pos_reg;
    logic [OFFSET_BITS-1:0] pos_next;
    logic [OFFSET_BITS-1:0] idx;
    logic [OFFSET_BITS-1:0] diff;
    logic                   done_reg;
    logic                   done_next;
    logic                   done_eff;
    logic                   enough;
    logic                   hit;
    logic                   emit;
    logic [OUT_OFFSET_W-1:0] offset_out;

    assign idx      = first_in_region ? '0 : pos_reg;
    assign done_eff = first_in_region ? 1'b0 : done_reg;
    assign pos_next = (idx != '1) ? idx + OFFSET_BITS'(1) : idx;
    assign enough   = idx >= OFFSET_BITS'(len_m1_reg);
    assign hit      = !done_eff && enough && (&eq_vec);
    // A match on the last byte wins over the not-found report.
    assign emit     = !done_eff && (hit || last_in_region);
    assign done_next = done_eff || emit;
    assign diff     = idx - OFFSET_BITS'(len_m1_reg);

    if (OFFSET_BITS >= OUT_OFFSET_W)
    begin : g_off_trunc
        assign offset_out = diff[OUT_OFFSET_W-1:0];
    end
    else
    begin : g_off_ext
        assign offset_out = OUT_OFFSET_W'(diff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            done_reg <= done_next;
        end
    end

    // Result register.
    logic                    found_reg;
    logic [OUT_OFFSET_W-1:0] offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept && emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            found_reg  <= hit;
            offset_reg <= hit ? offset_out : '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign found        = found_reg;
    assign match_offset = offset_reg;

endmodule

// ===== rtl/wbps_checker.sv =====
// Port-level checks for the wildcard byte pattern scanner, bound to its top level.
// Depends on wbps_pkg and wildcard_byte_pattern_scan_top.
module wbps_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              byte_valid,
    input logic                              byte_ready,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic                              found,
    input logic [wbps_pkg::OUT_OFFSET_W-1:0] match_offset,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite
);
    import wbps_pkg::*;

    // A result only ever appears just after a byte item was taken.
    a_result_follows_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(byte_valid && byte_ready))
        else $error("result appeared without a byte item");

    // A not-found report carries a zero offset.
    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !found) |-> (match_offset == '0))
        else $error("not-found result with non-zero offset");

    // Bytes are held off while a configuration write settles.
    a_cfg_pause: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite) |-> ##1 !byte_ready)
        else $error("byte taken right after a configuration write");

    // A stalled result keeps its value.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(found) && $stable(match_offset)))
        else $error("stalled result changed");

endmodule

bind wildcard_byte_pattern_scan_top wbps_checker u_wbps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .found        (found),
    .match_offset (match_offset),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite)
);

// ===== tb/sv/wildcard_byte_pattern_scan_top_tb.sv =====
// Self-checking testbench for wildcard_byte_pattern_scan_top: directed and random byte regions.
// Depends on wbps_pkg and the scanner RTL; carries its own prediction of every result item.
`timescale 1ns / 100ps

module wildcard_byte_pattern_scan_top_tb;

    import wbps_pkg::*;

    localparam int SIG_MAX      = SIGNATURE_MAX_DEF;
    localparam int RAND_ITEMS   = 1850;
    localparam int NUM_PHASES   = 12;
    // The result of a byte item shows in the cycle after acceptance; a settle wait of SETTLE_CYCLES is
    // allowed before the configuration port is touched or the run is judged.
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_REPORTS   = 10;

    // One result item as the scanner should present it.
    typedef struct packed {
        logic        found;
        logic [31:0] offset;
    } match_t;

    // Tracks the scanner's state alongside the RTL, works out the result (if any) of every
    // accepted byte item, and compares result items with the oldest outstanding prediction.
    class match_scoreboard;
        sig_bytes_t           sig;
        logic [WILD_W-1:0]    wild;
        logic [CFG_LEN_W-1:0] len_reg;
        logic [7:0]           window [SIG_MAX];
        logic [31:0]          position;
        bit                   done;
        match_t               expected_matches [$];
        int                   mismatches;

        function new();
            int k;
            sig        = '0;
            wild       = '0;
            len_reg    = CFG_LEN_W'(1);
            position   = '0;
            done       = 1'b0;
            mismatches = 0;
            for (k = 0; k < SIG_MAX; k++)
                window[k] = 8'h00;
        endfunction

        function void write_reg(reg_sel_t sel, logic [APB_DATA_W-1:0] value);
            case (sel)
                REG_SIG_A:   sig[7:0]   = value;
                REG_SIG_B:   sig[15:8]  = value;
                REG_SIG_C:   sig[23:16] = value;
                REG_SIG_D:   sig[31:24] = value;
                REG_WILD:    wild       = value[WILD_W-1:0];
                REG_SIG_LEN: len_reg    = value[CFG_LEN_W-1:0];
                default:     ;
            endcase
        endfunction

        // A length of zero behaves as one, and anything past the window behaves as the window.
        function int unsigned used_len();
            int unsigned n;
            n = len_reg;
            if (n == 0)
                n = 1;
            if (n > SIG_MAX)
                n = SIG_MAX;
            return n;
        endfunction

        function void take_byte(logic [7:0] b, bit first, bit last);
            int unsigned n;
            int          k;
            logic [31:0] idx;
            bit          hit;
            match_t      m;
            n = used_len();
            if (first)
            begin
                position = '0;
                done     = 1'b0;
            end
            for (k = SIG_MAX - 1; k > 0; k--)
                window[k] = window[k-1];
            window[0] = b;
            idx = position;
            if (position != '1)
                position++;
            if (done)
                return;
            // A start is only tried once the region has supplied a full signature of bytes.
            hit = 1'b0;
            if (idx >= n - 1)
            begin
                hit = 1'b1;
                for (k = 0; k < n; k++)
                    if (!wild[k] && window[n-1-k] != sig[k])
                        hit = 1'b0;
            end
            if (hit)
            begin
                m.found  = 1'b1;
                m.offset = idx - (n - 1);
                expected_matches = {expected_matches, m};
                done = 1'b1;
            end
            else if (last)
            begin
                m.found  = 1'b0;
                m.offset = 32'd0;
                expected_matches = {expected_matches, m};
                done = 1'b1;
            end
        endfunction

        function void check_match(logic f, logic [31:0] off);
            match_t exp_m;
            if (expected_matches.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result item found=%0b offset=%0d", $realtime, f, off);
                return;
            end
            exp_m = expected_matches.pop_front();
            if (f !== exp_m.found)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: found mismatch, expected %0b, got %0b",
                             $realtime, exp_m.found, f);
            end
            if (off !== exp_m.offset)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: match_offset mismatch, expected %0d, got %0d",
                             $realtime, exp_m.offset, off);
            end
        endfunction
    endclass

    // Clock, reset and every block input start at known values.
    logic                    clk             = 1'b0;
    logic                    rst_n           = 1'b0;
    logic                    byte_valid      = 1'b0;
    logic [7:0]              region_byte     = 8'h00;
    logic                    first_in_region = 1'b0;
    logic                    last_in_region  = 1'b0;
    logic                    result_ready    = 1'b0;
    logic                    psel            = 1'b0;
    logic                    penable         = 1'b0;
    logic                    pwrite          = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr           = '0;
    logic [APB_DATA_W-1:0]   pwdata          = '0;
    logic                    byte_ready;
    logic                    result_valid;
    logic                    found;
    logic [OUT_OFFSET_W-1:0] match_offset;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    match_scoreboard sb = new();

    // Percentages of cycles in which the sender and the receiver hold back.
    int send_idle_pct = 25;
    int recv_idle_pct = 75;
    // Byte items sent, counted afresh for the random phases.
    int live_items    = 0;

    wildcard_byte_pattern_scan_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_valid      (byte_valid),
        .byte_ready      (byte_ready),
        .region_byte     (region_byte),
        .first_in_region (first_in_region),
        .last_in_region  (last_in_region),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .found           (found),
        .match_offset    (match_offset),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Generous upper bound: the slowest correct run needs well under a tenth of this.
    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    // The receiver decides at every falling edge whether it takes a result item next cycle.
    always @(negedge clk)
    begin
        result_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Everything is sampled at the rising edge. A byte item accepted at this edge is noted
    // before any result item is checked, so the prediction is always in place in time.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
                sb.take_byte(region_byte, first_in_region, last_in_region);
            if (result_valid && result_ready)
                sb.check_match(found, match_offset);
        end
    end

    // Presents one byte item, with random idle cycles ahead of it, and holds it until taken.
    // Valid stays high from one item to the next unless the sender chooses to idle.
    task automatic send_byte(logic [7:0] b, bit first, bit last);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid = 1'b0;
            @(negedge clk);
        end
        live_items++;
        byte_valid      = 1'b1;
        region_byte     = b;
        first_in_region = first;
        last_in_region  = last;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
    endtask

    // Stops sending and waits until every predicted result item has been taken, then lets the
    // scanner settle. This is the only safe point for a configuration write.
    task automatic wait_drained();
        @(negedge clk);
        byte_valid = 1'b0;
        while (sb.expected_matches.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write in two phases, setup then access; the register takes the value at the edge
    // where the access phase meets pready.
    task automatic apb_write(reg_sel_t sel, logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {sel, {REG_SEL_LSB{1'b0}}};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_reg(sel, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic write_all(sig_bytes_t s, logic [WILD_W-1:0] w, logic [CFG_LEN_W-1:0] n);
        apb_write(REG_SIG_A, s[7:0]);
        apb_write(REG_SIG_B, s[15:8]);
        apb_write(REG_SIG_C, s[23:16]);
        apb_write(REG_SIG_D, s[31:24]);
        apb_write(REG_WILD, APB_DATA_W'(w));
        apb_write(REG_SIG_LEN, APB_DATA_W'(n));
    endtask

    // In narrow phases the region, and the signature unless the phase fixes it, draw on two byte
    // values only, so matches also turn up by chance and partial matches are frequent.
    function automatic logic [7:0] pick_byte(bit narrow);
        if (narrow)
            return $urandom_range(1) ? 8'hA5 : 8'h5A;
        return 8'($urandom_range(255));
    endfunction

    // Sends one region of random bytes. Most regions carry a planted copy of the signature
    // (wildcard positions filled at random), a quarter of those ending on the last byte. Unless
    // the region must be well formed, the first or last mark is sometimes left off, or a stray
    // mark falls in the middle.
    task automatic run_region(bit narrow, bit proper);
        logic [7:0]  region_data [0:127];
        int unsigned n;
        int          len;
        int          p;
        int          k;
        bit          fm;
        bit          lm;
        bit          f;
        bit          l;
        n = sb.used_len();
        if ($urandom_range(9) == 0)
            len = $urandom_range(1, 128);
        else
            len = $urandom_range(1, n + 24);
        for (k = 0; k < len; k++)
            region_data[k] = pick_byte(narrow);
        if (len >= n && $urandom_range(9) < 6)
        begin
            if ($urandom_range(3) == 0)
                p = len - n;
            else
                p = $urandom_range(0, len - n);
            for (k = 0; k < n; k++)
                region_data[p+k] = sb.wild[k] ? pick_byte(narrow) : sb.sig[k];
        end
        fm = proper || ($urandom_range(19) != 0);
        lm = proper || ($urandom_range(19) != 0);
        for (k = 0; k < len; k++)
        begin
            f = (k == 0) ? fm : (!proper && $urandom_range(49) == 0);
            l = (k == len - 1) ? lm : (!proper && $urandom_range(49) == 0);
            send_byte(region_data[k], f, l);
        end
    endtask

    // New settings for one random phase, with the extremes of every register among them.
    task automatic configure_phase(int ph);
        sig_bytes_t           s;
        logic [WILD_W-1:0]    w;
        logic [CFG_LEN_W-1:0] n;
        bit                   narrow;
        int                   k;
        narrow = (ph % 3 == 1);
        for (k = 0; k < SIG_REG_BYTES; k++)
            s[k] = pick_byte(narrow);
        w = $urandom & $urandom;
        n = CFG_LEN_W'($urandom_range(1, 12));
        case (ph)
            0:
            begin
                n = CFG_LEN_W'(1);
                w = '0;
            end
            1:
                n = CFG_LEN_W'(32);
            2:
                n = '0;           // zero length behaves as one
            3:
            begin
                n = '1;           // longest code, clipped to the full window
                w = '1;
            end
            4:
            begin
                s = '0;
                w = '0;
                n = CFG_LEN_W'($urandom_range(1, 8));
            end
            5:
            begin
                s = '1;
                w = $urandom;
                n = CFG_LEN_W'($urandom_range(1, 32));
            end
            default:
                ;
        endcase
        write_all(s, w, n);
    endtask

    initial
    begin
        sig_bytes_t s;
        int         ph;
        bit         narrow;

        // Reset once, released at a falling edge.
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: a three-byte signature 11 ?? 33 with the middle position wild.
        s = '0;
        s[0] = 8'h11;
        s[1] = 8'h22;
        s[2] = 8'h33;
        write_all(s, 32'h0000_0002, CFG_LEN_W'(3));

        // Match through the wildcard at offset 0; the byte after it, though last, is ignored.
        send_byte(8'h11, 1, 0);
        send_byte(8'h99, 0, 0);
        send_byte(8'h33, 0, 0);
        send_byte(8'h00, 0, 1);
        // Plain not-found region.
        send_byte(8'h11, 1, 0);
        send_byte(8'h44, 0, 0);
        send_byte(8'h00, 0, 1);
        // Regions shorter than the signature: the second would match on bytes left over from
        // the first, which must not count.
        send_byte(8'h11, 1, 0);
        send_byte(8'h77, 0, 1);
        send_byte(8'h33, 1, 1);
        // Match completed by the last byte wins over not found.
        send_byte(8'h00, 1, 0);
        send_byte(8'h11, 0, 0);
        send_byte(8'h00, 0, 0);
        send_byte(8'h33, 0, 1);
        // No first mark on the third byte: it continues the region, so the offset is 2.
        send_byte(8'hFF, 1, 0);
        send_byte(8'hFF, 0, 0);
        send_byte(8'h11, 0, 0);
        send_byte(8'h42, 0, 0);
        send_byte(8'h33, 0, 0);
        send_byte(8'hAB, 0, 1);

        // The sender waits here for every outstanding result before the length changes.
        wait_drained();
        apb_write(REG_SIG_LEN, '0);
        send_byte(8'h11, 1, 1);
        send_byte(8'h10, 1, 1);

        // Random phases: the idling pattern moves on every third of the way.
        live_items = 0;
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph < NUM_PHASES / 3)
            begin
                send_idle_pct = 25;
                recv_idle_pct = 75;
            end
            else if (ph < 2 * NUM_PHASES / 3)
            begin
                send_idle_pct = 75;
                recv_idle_pct = 25;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_drained();
            configure_phase(ph);
            narrow = (ph % 3 == 1);
            while (live_items < (ph + 1) * RAND_ITEMS / NUM_PHASES)
                run_region(narrow, 1'b0);
            // Close the phase with a complete region so the next settings start clean.
            run_region(narrow, 1'b1);
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.expected_matches.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/wbps_pkg.sv
rtl/wbps_regs.sv
rtl/wbps_cell.sv
rtl/wildcard_byte_pattern_scan_top.sv
rtl/wbps_checker.sv
tb/sv/wildcard_byte_pattern_scan_top_tb.sv
